@@ sv/fios_pkg.sv @@
// Package for the FIFO with indexed overwrite and search.
// Holds item types, operation and status codes, and controller/datapath interface structs.
// No dependencies.
package fios_pkg;

	// Default ring depth
	localparam int DEPTH_DEF = 16;

	// Operation codes
	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_OVW  = 2'd2;
	localparam logic [1:0] OP_SRCH = 2'd3;

	// Status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// Input item
	typedef struct packed {
		logic        [1:0]  opcode;
		logic signed [63:0] value;
		logic        [3:0]  position;
	} req_item_t;

	// Result item
	typedef struct packed {
		logic        [2:0]  status;
		logic signed [63:0] read_value;
		logic        [3:0]  found_position;
		logic        [4:0]  occupancy;
	} rsp_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       capture;    // latch the accepted item
		logic       enq;        // write tail, advance write pointer, count up
		logic       ovw;        // write entry at head + position
		logic       rd_head;    // read entry at head
		logic       pop;        // advance read pointer, count down
		logic       scan_init;  // restart the search scan
		logic       scan_step;  // read next entry of the scan
		logic       load;       // load the result register
		logic [2:0] status;     // status of the result
		logic       take_data;  // result carries the read data
		logic       take_pos;   // result carries the compared position
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] op;
		logic       empty;
		logic       full;
		logic       range_err;
		logic       cmp_valid;
		logic       hit;
		logic       last;
		logic       out_free;
	} dp_stat_t;

endpackage

@@ sv/fios_ctrl.sv @@
// Controller state machine for the FIFO with indexed overwrite and search.
// Depends on fios_pkg; drives commands to fios_dp and reads its status.
module fios_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  fios_pkg::dp_stat_t  stat,
	output fios_pkg::ctrl_cmd_t cmd
);
	import fios_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_stall = (state_q != S_IDLE);

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.op)
					OP_ENQ: begin
						if (stat.out_free) begin
							cmd.load = 1'b1;
							if (stat.full) begin
								cmd.status = ST_FULL;
							end else begin
								cmd.enq = 1'b1;
							end
							state_d = S_IDLE;
						end
					end
					OP_DEQ: begin
						if (stat.empty) begin
							if (stat.out_free) begin
								cmd.load   = 1'b1;
								cmd.status = ST_EMPTY;
								state_d    = S_IDLE;
							end
						end else begin
							cmd.rd_head = 1'b1;
							state_d     = S_READ;
						end
					end
					OP_OVW: begin
						if (stat.out_free) begin
							cmd.load = 1'b1;
							if (stat.range_err) begin
								cmd.status = ST_RANGE;
							end else begin
								cmd.ovw = 1'b1;
							end
							state_d = S_IDLE;
						end
					end
					default: begin
						if (stat.empty) begin
							if (stat.out_free) begin
								cmd.load   = 1'b1;
								cmd.status = ST_NOTFOUND;
								state_d    = S_IDLE;
							end
						end else begin
							cmd.scan_init = 1'b1;
							state_d       = S_SCAN;
						end
					end
				endcase
			end
			S_READ: begin
				if (stat.out_free) begin
					cmd.pop       = 1'b1;
					cmd.load      = 1'b1;
					cmd.take_data = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_SCAN: begin
				if (stat.cmp_valid && stat.hit) begin
					if (stat.out_free) begin
						cmd.load     = 1'b1;
						cmd.take_pos = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (stat.cmp_valid && stat.last) begin
					if (stat.out_free) begin
						cmd.load   = 1'b1;
						cmd.status = ST_NOTFOUND;
						state_d    = S_IDLE;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/fios_dp.sv @@
// Datapath for the FIFO with indexed overwrite and search: entry memory, ring
// pointers, count, search scan and result register. Depends on fios_pkg.
module fios_dp #(
	parameter int DEPTH = fios_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fios_pkg::req_item_t req,
	input  fios_pkg::ctrl_cmd_t cmd,
	output fios_pkg::dp_stat_t  stat,
	input  logic                rsp_stall,
	output logic                rsp_valid,
	output fios_pkg::rsp_item_t rsp
);
	import fios_pkg::*;

	localparam int PW = $clog2(DEPTH);       // ring index width
	localparam int CW = $clog2(DEPTH + 1);   // count width
	localparam int SW = PW + 1;              // ring sum width
	localparam int RW = (CW > 4) ? CW : 4;   // range compare width

	// Entry memory, no reset
	logic [63:0] mem_q [DEPTH];
	logic [63:0] rdata_q;

	// Captured item
	logic [1:0]  op_q;
	logic [63:0] value_q;
	logic [3:0]  pos_q;

	// Ring state
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;

	// Search scan
	logic [CW-1:0] iss_q;
	logic [CW-1:0] cmp_idx_s1;
	logic          cmp_valid_s1;

	// Result register
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	logic          we;
	logic [PW-1:0] waddr;
	logic          re;
	logic [PW-1:0] raddr;
	logic          out_free;

	// Head plus offset, modulo DEPTH; offset is below DEPTH when used
	function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
			input logic [SW-1:0] off);
		logic [SW-1:0] s;
		s = {1'b0, base} + off;
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Status to controller
	assign out_free        = !rsp_valid_q || !rsp_stall;
	assign stat.op         = op_q;
	assign stat.empty      = (count_q == '0);
	assign stat.full       = (count_q == CW'(DEPTH));
	assign stat.range_err  = (RW'(pos_q) >= RW'(count_q));
	assign stat.cmp_valid  = cmp_valid_s1;
	assign stat.hit        = (rdata_q == value_q);
	assign stat.last       = (CW'(cmp_idx_s1 + 1'b1) == count_q);
	assign stat.out_free   = out_free;

	// Memory port selection
	assign we    = cmd.enq || cmd.ovw;
	assign waddr = cmd.enq ? wp_q : ring_add(rp_q, SW'(pos_q));
	assign re    = cmd.rd_head || cmd.scan_step;
	assign raddr = cmd.rd_head ? rp_q : ring_add(rp_q, SW'(iss_q));

	// Count after this operation
	always_comb begin
		count_d = count_q;
		if (cmd.enq) begin
			count_d = count_q + 1'b1;
		end else if (cmd.pop) begin
			count_d = count_q - 1'b1;
		end
	end

	// Entry memory with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= value_q;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= req.opcode;
			value_q <= req.value;
			pos_q   <= req.position;
		end
	end

	// Pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q    <= '0;
			wp_q    <= '0;
			count_q <= '0;
		end else begin
			if (cmd.enq) begin
				wp_q <= ring_inc(wp_q);
			end
			if (cmd.pop) begin
				rp_q <= ring_inc(rp_q);
			end
			count_q <= count_d;
		end
	end

	// Search scan: issue one read a cycle, compare the previous one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q        <= '0;
			cmp_idx_s1   <= '0;
			cmp_valid_s1 <= 1'b0;
		end else if (cmd.scan_init) begin
			iss_q        <= '0;
			cmp_valid_s1 <= 1'b0;
		end else if (cmd.scan_step) begin
			iss_q        <= iss_q + 1'b1;
			cmp_idx_s1   <= iss_q;
			cmp_valid_s1 <= 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.status         <= cmd.status;
			rsp_q.read_value     <= cmd.take_data ? rdata_q : '0;
			rsp_q.found_position <= cmd.take_pos ? 4'(cmp_idx_s1) : 4'd0;
			rsp_q.occupancy      <= 5'(count_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Count never exceeds the ring depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// A held result is never overwritten
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> out_free)
		else $error("result loaded while previous one stalled");

	// Count only moves on enqueue or dequeue
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.enq && !cmd.pop) |=> $stable(count_q))
		else $error("count changed without enqueue or dequeue");

	// Enqueue never happens when full, dequeue never when empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.enq |-> !stat.full) and (cmd.pop |-> !stat.empty))
		else $error("ring overflow or underflow");

endmodule

@@ sv/fifo_with_indexed_overwrite_search.sv @@
// Bounded FIFO of signed 64-bit values in a ring of DEPTH entries, with four
// operations: enqueue, dequeue, overwrite at a position from the head, and
// search for the first entry equal to a value. Each item gives one result,
// carrying a status and the occupancy after the operation. One item is worked
// on at a time. Enqueue and overwrite finish in the execute state; dequeue
// and search go on through a read or scan state, since the entries sit in a
// memory with one registered read port and the search reads one entry per
// cycle from the head. A new item is accepted as soon as the previous one is
// finished, even while its result is still held. No clearing pass after reset.
// Depends on fios_pkg, fios_ctrl and fios_dp.
module fifo_with_indexed_overwrite_search #(
	parameter int DEPTH = fios_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  fios_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output fios_pkg::rsp_item_t rsp
);
	import fios_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Sequencer
	fios_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage, pointers and result register
	fios_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

@@ dv/fios_checker.sv @@
// Checker for the FIFO with indexed overwrite and search: watches both channels,
// predicts each result from its own copy of the ring and compares field by field.
// Depends on fios_pkg.
`timescale 1ns / 1ps
module fios_checker #(
	parameter int DEPTH = fios_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  fios_pkg::req_item_t req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  fios_pkg::rsp_item_t rsp,
	output int                  fail_count,
	output int                  pending
);
	import fios_pkg::*;

	localparam int REPORT_LIMIT = 10;

	// Shadow ring; entries are only read below the fill level
	logic signed [63:0] ring [DEPTH];
	int unsigned        head;
	int unsigned        tail;
	int unsigned        held;

	// Results owed by the block, oldest first
	rsp_item_t          due_results[$];
	int                 errors;

	// Apply one item to the shadow ring and return the result it owes
	function automatic rsp_item_t fifo_apply(req_item_t it);
		rsp_item_t res;
		bit        hit;
		res = '0;
		res.status = ST_OK;
		hit = 1'b0;
		case (it.opcode)
			OP_ENQ: begin
				if (held >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					ring[tail] = it.value;
					tail = (tail + 1) % DEPTH;
					held++;
				end
			end
			OP_DEQ: begin
				if (held == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.read_value = ring[head];
					head = (head + 1) % DEPTH;
					held--;
				end
			end
			OP_OVW: begin
				if (it.position >= held)
					res.status = ST_RANGE;
				else
					ring[(head + it.position) % DEPTH] = it.value;
			end
			default: begin
				// first match from the head wins
				for (int unsigned i = 0; i < held; i++) begin
					if (!hit && ring[(head + i) % DEPTH] == it.value) begin
						hit = 1'b1;
						res.found_position = 4'(i);
					end
				end
				if (!hit)
					res.status = ST_NOTFOUND;
			end
		endcase
		res.occupancy = 5'(held);
		return res;
	endfunction

	// Predict on every accepted item, compare on every accepted result
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			head = 0;
			tail = 0;
			held = 0;
			errors = 0;
			due_results.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (req_valid && !req_stall)
				due_results.push_back(fifo_apply(req));
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: result with none owed: status %0d value %0d pos %0d occ %0d",
							$realtime, rsp.status, rsp.read_value, rsp.found_position,
							rsp.occupancy);
				end else begin
					want = due_results.pop_front();
					if (rsp.status !== want.status || rsp.read_value !== want.read_value ||
						rsp.found_position !== want.found_position ||
						rsp.occupancy !== want.occupancy) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display({"%0t: mismatch: expected status %0d value %0d pos %0d ",
								"occ %0d, got status %0d value %0d pos %0d occ %0d"},
								$realtime, want.status, want.read_value,
								want.found_position, want.occupancy, rsp.status,
								rsp.read_value, rsp.found_position, rsp.occupancy);
					end
				end
			end
			fail_count <= errors;
			pending <= due_results.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
// Top of the testbench for fifo_with_indexed_overwrite_search: drives items and
// the result stall, runs the idling phases and gives the verdict.
// Depends on fios_pkg, fios_checker and the block itself.
`timescale 1ns / 1ps
module testbench;
	import fios_pkg::*;

	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int ITEMS_PER_PHASE = 320;
	localparam int MAX_GAP         = 20;
	localparam int SETTLE_CYCLES   = 40;

	localparam logic signed [63:0] VMAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] VMIN = 64'h8000_0000_0000_0000;
	localparam logic signed [63:0] STEP = 64'h0101_0101_0101_0101;
	localparam logic signed [63:0] MISS = 64'h5555_5555_5555_5555;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	int fail_count;
	int pending;
	int tx_pct = 0;
	int rx_pct = 0;
	int idle_cycles = 0;

	// values reused so that searches hit and duplicates occur
	logic signed [63:0] value_pool [8];

	fifo_with_indexed_overwrite_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	fios_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result side stalls at the phase rate
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rx_pct);
	end

	// Watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("fifo_with_indexed_overwrite_search verification failed");
			$finish;
		end
	end

	function automatic logic signed [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [63:0] pick_value();
		if ($urandom_range(9) < 7)
			return value_pool[3'($urandom_range(7))];
		return random_word();
	endfunction

	// Present one item, hold it until accepted, then maybe idle
	task automatic send(input logic [1:0] op, input logic signed [63:0] v,
		input logic [3:0] pos);
		req_item_t it;
		int        gap;
		it.opcode = op;
		it.value = v;
		it.position = pos;
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		gap = 0;
		while (tx_pct != 0 && gap < MAX_GAP && $urandom_range(99) < tx_pct)
			gap++;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) begin
				req <= {2'($urandom), random_word(), 4'($urandom)};
				@(posedge clk);
			end
		end
	endtask

	// Hold off the sender until every owed result has come back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [1:0] op;
		bit         filling;
		int         seg_left;
		int         r;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty cases, fill with extremes, full, search and overwrite edges
		send(OP_DEQ, '0, 4'd0);
		send(OP_SRCH, '0, 4'd0);
		send(OP_OVW, VMAX, 4'd0);
		send(OP_ENQ, VMAX, 4'd0);
		send(OP_ENQ, VMIN, 4'd15);
		send(OP_ENQ, -64'sd1, 4'd0);
		send(OP_ENQ, '0, 4'd0);
		for (int k = 1; k <= 12; k++)
			send(OP_ENQ, STEP * k, 4'(k));
		send(OP_ENQ, MISS, 4'd0);
		send(OP_SRCH, VMIN, 4'd0);
		send(OP_OVW, VMAX, 4'd15);
		send(OP_SRCH, VMAX, 4'd15);
		send(OP_DEQ, '0, 4'd0);
		send(OP_OVW, VMIN, 4'd15);
		send(OP_SRCH, MISS, 4'd15);
		drain();

		// Random phases: fill and drain segments with mixed operations
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_pct = 0;  rx_pct = 0;  end
				1: begin tx_pct = 46; rx_pct = 0;  end
				2: begin tx_pct = 0;  rx_pct = 46; end
				default: begin tx_pct = 24; rx_pct = 24; end
			endcase
			value_pool[0] = VMAX;
			value_pool[1] = VMIN;
			value_pool[2] = '0;
			value_pool[3] = -64'sd1;
			for (int k = 4; k < 8; k++)
				value_pool[k] = random_word();
			filling = 1'($urandom_range(1));
			seg_left = $urandom_range(60, 20);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (seg_left == 0) begin
					filling = !filling;
					seg_left = $urandom_range(60, 20);
				end
				seg_left--;
				r = $urandom_range(99);
				if (r < (filling ? 50 : 15))
					op = OP_ENQ;
				else if (r < 65)
					op = OP_DEQ;
				else if (r < 80)
					op = OP_OVW;
				else
					op = OP_SRCH;
				send(op, pick_value(), 4'($urandom_range(15)));
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("fifo_with_indexed_overwrite_search verification clean");
		else
			$display("fifo_with_indexed_overwrite_search verification failed");
		$finish;
	end

endmodule
